>>> rtl/nrmt_pkg.sv
`default_nettype none

package nrmt_pkg;

  // Table geometry
  localparam int unsigned LEVELS            = 8;
  localparam int unsigned ENTRIES_PER_LEVEL = 64;

  localparam int unsigned LVL_W     = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int unsigned ENT_W     = (ENTRIES_PER_LEVEL > 1) ? $clog2(ENTRIES_PER_LEVEL) : 1;
  localparam int unsigned CNT_W     = $clog2(ENTRIES_PER_LEVEL + 1);
  localparam int unsigned ADDR_W    = LVL_W + ENT_W;
  localparam int unsigned MEM_DEPTH = LEVELS * (2 ** ENT_W);

  // Field widths
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned LEVEL_W  = 3;
  localparam int unsigned RATE_W   = 32;
  localparam int unsigned STATE_W  = 16;
  localparam int unsigned FACTOR_W = 16;
  localparam int unsigned STS_W    = 2;

  // Stream packing
  localparam int unsigned IN_LEVEL_LSB = 0;
  localparam int unsigned IN_NODE_LSB  = IN_LEVEL_LSB + LEVEL_W;
  localparam int unsigned IN_STATE_LSB = IN_NODE_LSB + RATE_W;
  localparam int unsigned IN_QUERY_LSB = IN_STATE_LSB + STATE_W;
  localparam int unsigned IN_TDATA_W   = 88;

  localparam int unsigned OUT_STATE_LSB = 0;
  localparam int unsigned OUT_RATE_LSB  = OUT_STATE_LSB + STATE_W;
  localparam int unsigned OUT_DIFF_LSB  = OUT_RATE_LSB + RATE_W;
  localparam int unsigned OUT_TDATA_W   = 80;

  // Tolerance arithmetic: rate (Q16.16) times factor (Q8.8)
  localparam int unsigned PROD_W     = RATE_W + FACTOR_W;
  localparam int unsigned FRAC_SHIFT = 8;
  localparam int unsigned TOL_W      = PROD_W - FRAC_SHIFT;
  localparam logic [FACTOR_W-1:0] FACTOR_RESET = 16'd256;
  localparam logic [RATE_W-1:0]   WIDTH_CAP    = 32'h0064_0000;

  // Reciprocal divider: 2^32 / v, one quotient bit per step
  localparam int unsigned DIV_STEPS = RATE_W + 1;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS + 1);

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_RECORD = 2'd1,
    CMD_QUERY  = 2'd2
  } cmd_e;

  typedef enum logic [STS_W-1:0] {
    STS_DONE    = 2'd0,
    STS_MATCH   = 2'd1,
    STS_NOMATCH = 2'd2,
    STS_DROP    = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_RECIP,
    ST_WRITE,
    ST_SCAN,
    ST_DRAIN,
    ST_DECIDE,
    ST_FINISH
  } state_e;

  // Table write request from the sequencer
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [STATE_W-1:0] state;
    logic [RATE_W-1:0] rate;
  } mem_wr_t;

endpackage

`default_nettype wire

>>> rtl/nrmt_recip.sv
`default_nettype none

module nrmt_recip
  import nrmt_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [RATE_W-1:0] divisor_i,
  output logic              done_o,
  output logic [RATE_W-1:0] rate_o
);

  logic                 busy_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [RATE_W-1:0]    div_q;
  logic [RATE_W-1:0]    rem_q, rem_d;
  logic [RATE_W:0]      quo_q;
  logic [RATE_W:0]      trial;
  logic                 qbit;
  logic                 last_step;

  assign last_step = busy_q && (cnt_q == DIV_CNT_W'(DIV_STEPS - 1));

  // Dividend is a one followed by RATE_W zeros
  always_comb begin
    trial = {rem_q, (cnt_q == '0)};
    qbit  = (trial >= {1'b0, div_q});
    if (qbit) begin
      rem_d = RATE_W'(trial - {1'b0, div_q});
    end else begin
      rem_d = trial[RATE_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (last_step) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[RATE_W-1:0], qbit};
    end
  end

  assign done_o = last_step;
  // Saturate when the quotient needs the extra bit (divisor 0 or 1)
  assign rate_o = quo_q[RATE_W] ? '1 : quo_q[RATE_W-1:0];

endmodule

`default_nettype wire

>>> rtl/nrmt_mem.sv
`default_nettype none

module nrmt_mem
  import nrmt_pkg::*;
(
  input  logic               clk_i,
  input  mem_wr_t            wr_i,
  input  logic [ADDR_W-1:0]  rd_addr_i,
  output logic [STATE_W-1:0] rd_state_o,
  output logic [RATE_W-1:0]  rd_rate_o
);

  logic [STATE_W-1:0] state_mem [MEM_DEPTH];
  logic [RATE_W-1:0]  rate_mem  [MEM_DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      state_mem[wr_i.addr] <= wr_i.state;
      rate_mem[wr_i.addr]  <= wr_i.rate;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_state_o <= state_mem[rd_addr_i];
    rd_rate_o  <= rate_mem[rd_addr_i];
  end

endmodule

`default_nettype wire

>>> rtl/nearest_rate_match_table.sv
// Nearest rate match table.
// Input stream (s_axis_*): one command per item, command in tuser. Clear
// empties every level list, record appends (state, 2^32/node_value) to a
// level, query returns the entry of a level closest to the query rate.
// Output stream (m_axis_*): exactly one result item per input item, status
// in tuser, matched state, rate and difference in tdata.
// Configuration: cfg_wr_en_i writes the Q8.8 tolerance factor on the clock
// edge; write it only while no item is in flight.
// Flow: one item at a time; tready is high only while the sequencer idles.
// Clear and unused commands go from idle straight to the finish state; a
// dropped record or a query of an empty level passes the lookup state first.
// A record waits in the recip state for the one-bit-per-cycle reciprocal
// divider (33 steps), then writes the table. A query visits the entries of
// its level one per cycle via the single table read port and compare unit.
// The result sits in an output register, so the next item is taken while a
// result waits; a stalled receiver stops the block only once a second
// result is ready. Reset empties all lists and sets the factor to 1.0; the
// table storage itself is not cleared.
`default_nettype none

module nearest_rate_match_table
  import nrmt_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // configuration
  input  logic                   cfg_wr_en_i,
  input  logic [FACTOR_W-1:0]    cfg_wr_data_i,
  // input items
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // level[2:0], node_value[34:3], state_value[50:35], query_rate[82:51]
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // command[1:0]
  input  logic [CMD_W-1:0]       s_axis_tuser,
  // result items
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // match_state[15:0], matched_rate[47:16], difference[79:48]
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // status[1:0]
  output logic [STS_W-1:0]       m_axis_tuser
);

  state_e state_q, state_d;

  // Input field split
  logic [LEVEL_W-1:0] in_level;
  logic [RATE_W-1:0]  in_node;
  logic [STATE_W-1:0] in_state;
  logic [RATE_W-1:0]  in_query;
  assign in_level = s_axis_tdata[IN_LEVEL_LSB +: LEVEL_W];
  assign in_node  = s_axis_tdata[IN_NODE_LSB +: RATE_W];
  assign in_state = s_axis_tdata[IN_STATE_LSB +: STATE_W];
  assign in_query = s_axis_tdata[IN_QUERY_LSB +: RATE_W];

  logic [LVL_W+LEVEL_W-1:0] in_level_ext;
  assign in_level_ext = (LVL_W + LEVEL_W)'(in_level);

  logic [FACTOR_W-1:0] factor_q;
  logic [CNT_W-1:0]    fill_q [LEVELS];

  logic [CMD_W-1:0]   cmd_q;
  logic [LVL_W-1:0]   lvl_q;
  logic               lvl_ok_q;
  logic [RATE_W-1:0]  node_q;
  logic [STATE_W-1:0] st_q;
  logic [RATE_W-1:0]  query_q;
  logic [PROD_W-1:0]  prod_q;

  logic [ENT_W-1:0]   rd_idx_q;
  logic [CNT_W-1:0]   cnt_q;
  logic               cmp_vld_q, cmp_first_q;
  logic [RATE_W-1:0]  best_diff_q, best_rate_q;
  logic [STATE_W-1:0] best_state_q;

  logic [STS_W-1:0]   res_status_q;
  logic [STATE_W-1:0] res_state_q;
  logic [RATE_W-1:0]  res_rate_q, res_diff_q;

  logic               m_valid_q;
  logic [STS_W-1:0]   m_status_q;
  logic [OUT_TDATA_W-1:0] m_data_q;

  // Sequencer outputs
  logic accept, div_start, scan_issue, scan_last, out_load;
  logic div_done;
  logic [RATE_W-1:0] div_rate;

  logic [CNT_W-1:0] fill_sel;
  logic             lvl_full, lvl_empty;
  assign fill_sel  = fill_q[lvl_q];
  assign lvl_full  = (fill_sel >= CNT_W'(ENTRIES_PER_LEVEL));
  assign lvl_empty = (fill_sel == '0);
  assign scan_last = (CNT_W'(rd_idx_q) + 1'b1 == cnt_q);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          case (s_axis_tuser)
            CMD_RECORD, CMD_QUERY: state_d = ST_LOOKUP;
            default:               state_d = ST_FINISH;
          endcase
        end
      end
      ST_LOOKUP: begin
        case (cmd_q)
          CMD_RECORD: state_d = (lvl_ok_q && !lvl_full) ? ST_RECIP : ST_FINISH;
          CMD_QUERY:  state_d = (lvl_ok_q && !lvl_empty) ? ST_SCAN : ST_FINISH;
          default:    state_d = ST_FINISH;
        endcase
      end
      ST_RECIP:  if (div_done) state_d = ST_WRITE;
      ST_WRITE:  state_d = ST_FINISH;
      ST_SCAN:   if (scan_last) state_d = ST_DRAIN;
      ST_DRAIN:  state_d = ST_DECIDE;
      ST_DECIDE: state_d = ST_FINISH;
      ST_FINISH: if (!m_valid_q || m_axis_tready) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    s_axis_tready = 1'b0;
    div_start     = 1'b0;
    scan_issue    = 1'b0;
    out_load      = 1'b0;
    case (state_q)
      ST_IDLE:   s_axis_tready = 1'b1;
      ST_LOOKUP: div_start = (cmd_q == CMD_RECORD) && lvl_ok_q && !lvl_full;
      ST_SCAN:   scan_issue = 1'b1;
      ST_FINISH: out_load = !m_valid_q || m_axis_tready;
      default: ;
    endcase
  end

  assign accept = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      factor_q <= FACTOR_RESET;
    end else if (cfg_wr_en_i) begin
      factor_q <= cfg_wr_data_i;
    end
  end

  // Level fill counts
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LEVELS; i++) begin
        fill_q[i] <= '0;
      end
    end else if (accept && (s_axis_tuser == CMD_CLEAR)) begin
      for (int i = 0; i < LEVELS; i++) begin
        fill_q[i] <= '0;
      end
    end else if (state_q == ST_WRITE) begin
      fill_q[lvl_q] <= fill_sel + 1'b1;
    end
  end

  // Reciprocal unit
  nrmt_recip u_recip (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .divisor_i (node_q),
    .done_o    (div_done),
    .rate_o    (div_rate)
  );

  // Table storage
  mem_wr_t            mem_wr;
  logic [ADDR_W-1:0]  rd_addr;
  logic [STATE_W-1:0] rd_state;
  logic [RATE_W-1:0]  rd_rate;

  always_comb begin
    mem_wr.we    = (state_q == ST_WRITE);
    mem_wr.addr  = {lvl_q, fill_sel[ENT_W-1:0]};
    mem_wr.state = st_q;
    mem_wr.rate  = div_rate;
  end
  assign rd_addr = {lvl_q, rd_idx_q};

  nrmt_mem u_mem (
    .clk_i      (clk_i),
    .wr_i       (mem_wr),
    .rd_addr_i  (rd_addr),
    .rd_state_o (rd_state),
    .rd_rate_o  (rd_rate)
  );

  // Compare unit: one entry per cycle
  logic [RATE_W-1:0] cur_diff;
  logic              take_cur;
  assign cur_diff = (query_q >= rd_rate) ? (query_q - rd_rate) : (rd_rate - query_q);
  assign take_cur = cmp_first_q || (cur_diff < best_diff_q);

  // Tolerance and decision
  logic [TOL_W-1:0]  tol_raw;
  logic [RATE_W-1:0] tol;
  logic              is_match;
  assign tol_raw  = prod_q[PROD_W-1:FRAC_SHIFT];
  assign tol      = (tol_raw > TOL_W'(WIDTH_CAP)) ? WIDTH_CAP : tol_raw[RATE_W-1:0];
  assign is_match = (best_diff_q <= tol);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmp_vld_q   <= 1'b0;
      cmp_first_q <= 1'b0;
    end else begin
      cmp_vld_q   <= scan_issue;
      cmp_first_q <= scan_issue && (rd_idx_q == '0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q    <= s_axis_tuser;
      lvl_q    <= in_level_ext[LVL_W-1:0];
      lvl_ok_q <= (32'(in_level) < LEVELS);
      node_q   <= in_node;
      st_q     <= in_state;
      query_q  <= in_query;
      prod_q   <= PROD_W'(in_query) * PROD_W'(factor_q);
    end

    if (state_q == ST_LOOKUP) begin
      rd_idx_q <= '0;
      cnt_q    <= fill_sel;
    end else if (scan_issue) begin
      rd_idx_q <= rd_idx_q + 1'b1;
    end

    if (cmp_vld_q && take_cur) begin
      best_diff_q  <= cur_diff;
      best_rate_q  <= rd_rate;
      best_state_q <= rd_state;
    end

    // Result data: zero unless a query found a non-empty level (state only on a match)
    if (accept) begin
      res_status_q <= STS_DONE;
      res_state_q  <= '0;
      res_rate_q   <= '0;
      res_diff_q   <= '0;
    end else if (state_q == ST_LOOKUP) begin
      case (cmd_q)
        CMD_RECORD: res_status_q <= (lvl_ok_q && !lvl_full) ? STS_DONE : STS_DROP;
        CMD_QUERY:  res_status_q <= STS_NOMATCH;
        default:    res_status_q <= STS_DONE;
      endcase
    end else if (state_q == ST_DECIDE) begin
      res_status_q <= is_match ? STS_MATCH : STS_NOMATCH;
      res_state_q  <= is_match ? best_state_q : '0;
      res_rate_q   <= best_rate_q;
      res_diff_q   <= best_diff_q;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_status_q <= res_status_q;
      m_data_q   <= OUT_TDATA_W'({res_diff_q, res_rate_q, res_state_q});
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_status_q;
  assign m_axis_tdata  = m_data_q;

`ifndef NO_ASSERTIONS
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> (fill_sel <= CNT_W'(ENTRIES_PER_LEVEL)))
    else $error("level fill count above capacity");

  a_write_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_wr.we |-> !lvl_full && lvl_ok_q)
    else $error("table write into a full or invalid level");

  a_div_done_in_recip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == ST_RECIP)
    else $error("reciprocal finished outside its wait state");

  a_match_in_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && (m_status_q == STS_MATCH)) |->
      (m_data_q[OUT_DIFF_LSB +: RATE_W] <= WIDTH_CAP))
    else $error("match reported beyond the tolerance cap");

  a_scan_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_issue |-> (cnt_q != '0) && (CNT_W'(rd_idx_q) < cnt_q))
    else $error("scan read beyond the level fill count");
`endif

endmodule

`default_nettype wire

>>> bench/nearest_rate_match_table_checker.sv
module nearest_rate_match_table_checker
  import nrmt_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_wr_en_i,
  input  logic [FACTOR_W-1:0]    cfg_wr_data_i,
  input  logic                   s_axis_tvalid,
  input  logic                   s_axis_tready,
  // level[2:0], node_value[34:3], state_value[50:35], query_rate[82:51]
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // command[1:0]
  input  logic [CMD_W-1:0]       s_axis_tuser,
  input  logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // match_state[15:0], matched_rate[47:16], difference[79:48]
  input  logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // status[1:0]
  input  logic [STS_W-1:0]       m_axis_tuser,
  output int                     pending_o,
  output int                     errors_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    status_e            status;
    logic [STATE_W-1:0] state;
    logic [RATE_W-1:0]  rate;
    logic [RATE_W-1:0]  diff;
  } answer_t;

  logic [FACTOR_W-1:0] match_factor;
  logic [CNT_W-1:0]    level_fill  [LEVELS];
  logic [STATE_W-1:0]  entry_state [LEVELS][ENTRIES_PER_LEVEL];
  logic [RATE_W-1:0]   entry_rate  [LEVELS][ENTRIES_PER_LEVEL];
  answer_t             awaited_answers [$];
  answer_t             want;
  logic [RATE_W-1:0]   got_state, got_rate, got_diff;

  function automatic logic [RATE_W-1:0] rate_gap(input logic [RATE_W-1:0] a,
                                                 input logic [RATE_W-1:0] b);
    return (a >= b) ? a - b : b - a;
  endfunction

  // Update the table copy for one command and return the answer it produces.
  function automatic answer_t apply_command(input logic [CMD_W-1:0]   cmd,
                                            input logic [LEVEL_W-1:0] lvl,
                                            input logic [RATE_W-1:0]  node,
                                            input logic [STATE_W-1:0] st,
                                            input logic [RATE_W-1:0]  q);
    answer_t            ans;
    logic [63:0]        quot;
    logic [RATE_W-1:0]  d, best_diff;
    logic [PROD_W-1:0]  tol;
    int                 best;
    ans.status = STS_DONE;
    ans.state  = '0;
    ans.rate   = '0;
    ans.diff   = '0;
    case (cmd)
      CMD_CLEAR: begin
        foreach (level_fill[i]) level_fill[i] = '0;
      end
      CMD_RECORD: begin
        if (lvl >= LEVELS || level_fill[lvl] >= ENTRIES_PER_LEVEL) begin
          ans.status = STS_DROP;
        end else begin
          // saturate the reciprocal for node values of 0 and 1
          quot = (node <= 1) ? 64'hFFFF_FFFF : 64'h1_0000_0000 / {32'b0, node};
          entry_state[lvl][level_fill[lvl]] = st;
          entry_rate[lvl][level_fill[lvl]]  = quot[RATE_W-1:0];
          level_fill[lvl] = level_fill[lvl] + 1'b1;
        end
      end
      CMD_QUERY: begin
        ans.status = STS_NOMATCH;
        if (lvl < LEVELS && level_fill[lvl] != 0) begin
          best      = 0;
          best_diff = rate_gap(q, entry_rate[lvl][0]);
          for (int i = 1; i < level_fill[lvl]; i++) begin
            d = rate_gap(q, entry_rate[lvl][i]);
            // strict compare keeps the earliest entry on a tie
            if (d < best_diff) begin
              best_diff = d;
              best      = i;
            end
          end
          tol = ({16'b0, q} * {32'b0, match_factor}) >> FRAC_SHIFT;
          if (tol > WIDTH_CAP) tol = WIDTH_CAP;
          ans.rate = entry_rate[lvl][best];
          ans.diff = best_diff;
          if (best_diff <= tol) begin
            ans.status = STS_MATCH;
            ans.state  = entry_state[lvl][best];
          end
        end
      end
      default: ;
    endcase
    return ans;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_factor = FACTOR_RESET;
      foreach (level_fill[i]) level_fill[i] = '0;
      awaited_answers.delete();
      errors_o  <= 0;
      pending_o <= 0;
    end else begin
      if (cfg_wr_en_i) match_factor = cfg_wr_data_i;
      if (m_axis_tvalid && m_axis_tready) begin
        got_state = RATE_W'(m_axis_tdata[OUT_STATE_LSB +: STATE_W]);
        got_rate  = m_axis_tdata[OUT_RATE_LSB +: RATE_W];
        got_diff  = m_axis_tdata[OUT_DIFF_LSB +: RATE_W];
        if (awaited_answers.size() == 0) begin
          if (errors_o < 10)
            $display("%0t: result item with nothing outstanding: status %0d state %h",
                     $realtime, m_axis_tuser, got_state);
          errors_o <= errors_o + 1;
        end else begin
          want = awaited_answers.pop_front();
          if (m_axis_tuser !== want.status || got_state !== RATE_W'(want.state) ||
              got_rate !== want.rate || got_diff !== want.diff) begin
            if (errors_o < 10)
              $display({"%0t: wrong result item (expected / actual): status %0d / %0d, ",
                        "state %h / %h, rate %h / %h, diff %h / %h"},
                       $realtime, want.status, m_axis_tuser, want.state, got_state,
                       want.rate, got_rate, want.diff, got_diff);
            errors_o <= errors_o + 1;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        awaited_answers.insert(awaited_answers.size(), apply_command(
          s_axis_tuser,
          s_axis_tdata[IN_LEVEL_LSB +: LEVEL_W],
          s_axis_tdata[IN_NODE_LSB +: RATE_W],
          s_axis_tdata[IN_STATE_LSB +: STATE_W],
          s_axis_tdata[IN_QUERY_LSB +: RATE_W]));
      pending_o <= awaited_answers.size();
    end
  end

endmodule

>>> bench/nearest_rate_match_table_tb.sv
module nearest_rate_match_table_tb;
  import nrmt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int QUIET_LIMIT = 2000;
  localparam int RECENT_MAX  = 32;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   cfg_wr_en_i   = 1'b0;
  logic [FACTOR_W-1:0]    cfg_wr_data_i = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic [CMD_W-1:0]       s_axis_tuser  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [STS_W-1:0]       m_axis_tuser;

  int pending, errors;
  int sender_idle_pct   = 0;
  int receiver_stall_pct = 0;
  int quiet_cycles      = 0;

  // rates recently stored, used to aim queries near real entries
  logic [RATE_W-1:0]  recent_rate  [$];
  logic [LEVEL_W-1:0] recent_level [$];

  nearest_rate_match_table uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  nearest_rate_match_table_checker answer_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .pending_o     (pending),
    .errors_o      (errors)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("nearest_rate_match_table: mismatch");
      $finish;
    end
  end

  task automatic send_item(input logic [CMD_W-1:0]   cmd,
                           input logic [LEVEL_W-1:0] lvl,
                           input logic [RATE_W-1:0]  node,
                           input logic [STATE_W-1:0] st,
                           input logic [RATE_W-1:0]  q);
    logic [IN_TDATA_W-1:0] data;
    int gap;
    gap = 0;
    while ($urandom_range(99) < sender_idle_pct) gap++;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    data = '0;
    data[IN_LEVEL_LSB +: LEVEL_W] = lvl;
    data[IN_NODE_LSB +: RATE_W]   = node;
    data[IN_STATE_LSB +: STATE_W] = st;
    data[IN_QUERY_LSB +: RATE_W]  = q;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    s_axis_tuser  <= cmd;
    do @(posedge clk_i); while (!s_axis_tready);
    if (cmd == CMD_CLEAR) begin
      recent_rate.delete();
      recent_level.delete();
    end else if (cmd == CMD_RECORD) begin
      // rough reciprocal is enough to land queries near an entry
      recent_rate.insert(recent_rate.size(),
                         (node < 2) ? 32'hFFFF_FFFF : 32'hFFFF_FFFF / node);
      recent_level.insert(recent_level.size(), lvl);
      if (recent_rate.size() > RECENT_MAX) begin
        void'(recent_rate.pop_front());
        void'(recent_level.pop_front());
      end
    end
  endtask

  // Hold the sender until every outstanding result item has been taken.
  task automatic wait_for_answers();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic write_factor(input logic [FACTOR_W-1:0] factor);
    cfg_wr_en_i   <= 1'b1;
    cfg_wr_data_i <= factor;
    @(posedge clk_i);
    cfg_wr_en_i   <= 1'b0;
  endtask

  function automatic logic [RATE_W-1:0] random_node();
    case ($urandom_range(3))
      0:       return $urandom;
      1:       return $urandom_range(255);
      2:       return $urandom_range(32'h0000_FFFF, 256);
      default: return $urandom_range(32'h00FF_FFFF, 32'h0001_0000);
    endcase
  endfunction

  function automatic logic [RATE_W-1:0] random_rate();
    return $urandom_range(1) ? $urandom : $urandom_range(32'h00FF_FFFF);
  endfunction

  task automatic random_items(input int count);
    int pick, idx, k;
    logic [LEVEL_W-1:0] lvl;
    logic [RATE_W-1:0]  q, span;
    for (k = 0; k < count; k++) begin
      pick = $urandom_range(199);
      lvl  = ($urandom_range(99) < 40) ? '0 : LEVEL_W'($urandom_range(7));
      if (pick == 0) begin
        send_item(CMD_CLEAR, lvl, $urandom, $urandom, $urandom);
      end else if (pick < 5) begin
        send_item(CMD_UNUSED, lvl, $urandom, $urandom, $urandom);
      end else if (pick < 90) begin
        send_item(CMD_RECORD, lvl, random_node(), $urandom, $urandom);
      end else if (pick < 165 && recent_rate.size() > 0) begin
        // aim at a stored rate: exact, a few LSBs off, or a fraction of it off
        idx = $urandom_range(recent_rate.size() - 1);
        q   = recent_rate[idx];
        case ($urandom_range(2))
          0: ;
          1: q = q + RATE_W'($urandom_range(16)) - 32'd8;
          default: begin
            span = q >> $urandom_range(8, 1);
            q    = $urandom_range(1) ? q + span : q - span;
          end
        endcase
        send_item(CMD_QUERY, recent_level[idx], $urandom, $urandom, q);
      end else begin
        send_item(CMD_QUERY, lvl, $urandom, $urandom, random_rate());
      end
      if ($urandom_range(63) == 0) wait_for_answers();
    end
  endtask

  initial begin
    logic [LEVEL_W-1:0] burst_level;
    int k;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty level, saturated reciprocal, tie, tolerance limits
    send_item(CMD_QUERY,  3'd0, '0, '0, 32'h0001_0000);
    send_item(CMD_RECORD, 3'd0, 32'h0000_0000, 16'hFFFF, '0);
    send_item(CMD_RECORD, 3'd0, 32'h0000_0001, 16'h0000, 32'hFFFF_FFFF);
    send_item(CMD_QUERY,  3'd0, '0, '0, 32'hFFFF_FFFF);
    send_item(CMD_RECORD, 3'd7, 32'hFFFF_FFFF, 16'h5555, '0);
    send_item(CMD_RECORD, 3'd7, 32'h0001_0000, 16'hAAAA, '0);
    send_item(CMD_QUERY,  3'd7, '0, '0, 32'h0000_0000);
    send_item(CMD_QUERY,  3'd7, '0, '0, 32'h0000_8000);
    send_item(CMD_QUERY,  3'd7, '0, '0, 32'hFFFF_FFFF);
    send_item(CMD_QUERY,  3'd3, '1, '1, 32'h0000_0001);
    send_item(CMD_UNUSED, 3'd7, '1, '1, '1);
    send_item(CMD_CLEAR,  3'd7, '1, '1, '1);
    send_item(CMD_QUERY,  3'd0, '0, '0, 32'hFFFF_FFFF);
    send_item(CMD_RECORD, 3'd3, 32'h0000_0003, 16'h1234, '0);
    send_item(CMD_QUERY,  3'd3, '0, '0, 32'h5555_5555);
    wait_for_answers();

    // half tolerance: a gap equal to the width matches, one more does not
    sender_idle_pct = 67;
    write_factor(16'd128);
    send_item(CMD_CLEAR,  3'd4, '0, '0, '0);
    send_item(CMD_RECORD, 3'd4, 32'hFFFF_FFFF, 16'h0F0F, '0);
    send_item(CMD_QUERY,  3'd4, '0, '0, 32'd2);
    send_item(CMD_QUERY,  3'd4, '0, '0, 32'd3);
    // overfill one level so the last records are dropped
    burst_level = LEVEL_W'($urandom_range(7));
    for (k = 0; k < ENTRIES_PER_LEVEL + 2; k++)
      send_item(CMD_RECORD, burst_level, random_node(), $urandom, $urandom);
    random_items(80);
    wait_for_answers();

    sender_idle_pct    = 0;
    receiver_stall_pct = 67;
    write_factor(16'd0);
    random_items(160);
    wait_for_answers();

    sender_idle_pct    = 33;
    receiver_stall_pct = 33;
    write_factor(16'hFFFF);
    random_items(160);
    wait_for_answers();

    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    write_factor(FACTOR_RESET);
    random_items(160);
    wait_for_answers();

    repeat (10) @(posedge clk_i);
    if (errors == 0) begin
      $display("nearest_rate_match_table: match");
    end else begin
      $display("nearest_rate_match_table: mismatch");
    end
    $finish;
  end

endmodule
